### rtl/xrr_pkg.sv
// ----------------------------------------------------------------------------
// xrr_pkg
// Shared types, codes and helpers of the ranged xorshift generator.
// ----------------------------------------------------------------------------
package xrr_pkg;

  localparam int unsigned HALF_W  = 16;
  localparam int unsigned WORD_W  = 2 * HALF_W;
  localparam int unsigned SHIFT_A = 5;
  localparam int unsigned SHIFT_B = 7;
  localparam int unsigned SHIFT_C = 4;

  localparam logic [HALF_W-1:0] SEED_FIRST_RST  = 16'd12345;
  localparam logic [HALF_W-1:0] SEED_SECOND_RST = 16'd54321;

  // operation codes
  localparam logic [1:0] OP_DRAW16 = 2'd0;
  localparam logic [1:0] OP_DRAW32 = 2'd1;
  localparam logic [1:0] OP_RESEED = 2'd2;

  // configuration register indexes
  localparam logic CFG_SEED_FIRST  = 1'b0;
  localparam logic CFG_SEED_SECOND = 1'b1;

  // what the chain carries for an item
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_DRAW16 = 2'd1;
  localparam logic [1:0] KIND_DRAW32 = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] rem;      // partial remainder
    logic [WORD_W-1:0] raw;      // dividend bits, next one at the top
    logic [WORD_W-1:0] divisor;  // span + 1, zero for a full 32-bit span
    logic [WORD_W-1:0] low;
    logic [1:0]        kind;
    logic              err;
  } xrr_lane_t;

  // one generator step: returns the new second word
  function automatic logic [HALF_W-1:0] xrr_next(input logic [HALF_W-1:0] s1,
                                                 input logic [HALF_W-1:0] s2);
    logic [HALF_W-1:0] t;
    t = s1 ^ (s1 << SHIFT_A);
    return s2 ^ (s2 >> SHIFT_C) ^ t ^ (t >> SHIFT_B);
  endfunction

endpackage

### rtl/xrr_gen.sv
// ----------------------------------------------------------------------------
// xrr_gen
// Seed registers and the two state words; advances once per accepted item.
// ----------------------------------------------------------------------------
module xrr_gen
  import xrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [HALF_W-1:0] cfg_data,
  input  logic              step,
  input  logic [1:0]        operation,
  output logic [WORD_W-1:0] raw,
  output logic              seed_error
);

  logic [HALF_W-1:0] seed_first_r, seed_second_r;
  logic [HALF_W-1:0] first_word_r, second_word_r;
  logic [HALF_W-1:0] first_word_nxt, second_word_nxt;
  logic [HALF_W-1:0] n1, n2;
  logic              seed_zero;

  assign n1        = xrr_next(first_word_r, second_word_r);
  assign n2        = xrr_next(second_word_r, n1);
  assign seed_zero = (seed_first_r == '0) || (seed_second_r == '0);

  always_comb begin
    first_word_nxt  = first_word_r;
    second_word_nxt = second_word_r;
    raw             = '0;
    seed_error      = 1'b0;
    unique case (operation)
      OP_DRAW16: begin
        first_word_nxt  = second_word_r;
        second_word_nxt = n1;
        raw             = {{HALF_W{1'b0}}, n1};
      end
      OP_DRAW32: begin
        first_word_nxt  = n1;
        second_word_nxt = n2;
        raw             = {n1, n2};
      end
      OP_RESEED: begin
        seed_error = seed_zero;
        if (!seed_zero) begin
          first_word_nxt  = seed_first_r;
          second_word_nxt = seed_second_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_first_r  <= SEED_FIRST_RST;
      seed_second_r <= SEED_SECOND_RST;
      first_word_r  <= SEED_FIRST_RST;
      second_word_r <= SEED_SECOND_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEED_FIRST) begin
          seed_first_r <= cfg_data;
        end else begin
          seed_second_r <= cfg_data;
        end
      end
      if (step) begin
        first_word_r  <= first_word_nxt;
        second_word_r <= second_word_nxt;
      end
    end
  end

endmodule

### rtl/xrr_cell.sv
// ----------------------------------------------------------------------------
// xrr_cell
// One restoring remainder step: shift in one dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module xrr_cell
  import xrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      valid_in,
  input  xrr_lane_t lane_in,
  output logic      valid_out,
  output xrr_lane_t lane_out
);

  logic              valid_r;
  xrr_lane_t         lane_r, lane_nxt;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              fits;

  assign shifted = {lane_in.rem, lane_in.raw[WORD_W-1]};
  assign fits    = shifted >= {1'b0, lane_in.divisor};
  assign diff    = shifted - {1'b0, lane_in.divisor};

  // a zero divisor (full 32-bit span) always fits, so rem collects raw itself
  always_comb begin
    lane_nxt     = lane_in;
    lane_nxt.raw = {lane_in.raw[WORD_W-2:0], 1'b0};
    lane_nxt.rem = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign valid_out = valid_r;
  assign lane_out  = lane_r;

endmodule

### rtl/xorshift16_ranged_random_top.sv
// ----------------------------------------------------------------------------
// xorshift16_ranged_random_top
// Two-word 16-bit xorshift generator with draws reduced into [low, high].
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: operation, range_low, range_high
//  out_    | out | out_tvalid/tready  | tdata: value, seed_error
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (seed registers)
//
//  One item accepted per cycle unless a held result stalls the chain.
//  Each result passes through 32 remainder cells (one dividend bit each),
//  the first capturing at the edge that accepts its item, then the output
//  register. State words advance at acceptance; the chain never waits on them.
//  A held result freezes the whole chain and drops in_tready.
//  Reset loads seeds 12345 / 54321 into both seed and state words, chain empty.
// ----------------------------------------------------------------------------
module xorshift16_ranged_random_top
  import xrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // operation[1:0], range_low[33:2], range_high[65:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // value[31:0], seed_error[32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CELLS = WORD_W;

  logic [1:0]        operation;
  logic [WORD_W-1:0] range_low, range_high;
  logic              en, accept;
  logic [WORD_W-1:0] raw;
  logic              gen_err;
  logic [WORD_W-1:0] span32;
  logic [HALF_W-1:0] span16;
  xrr_lane_t         entry;
  xrr_lane_t         lanes [CELLS+1];
  logic              valids [CELLS+1];
  xrr_lane_t         last;
  logic [WORD_W-1:0] value_nxt;
  logic [HALF_W-1:0] sum16;

  logic              out_valid_r;
  logic [WORD_W-1:0] value_r;
  logic              seed_error_r;

  assign operation  = in_tdata[1:0];
  assign range_low  = in_tdata[33:2];
  assign range_high = in_tdata[65:34];

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign cfg_ready = 1'b1;

  xrr_gen u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (accept),
    .operation  (operation),
    .raw        (raw),
    .seed_error (gen_err)
  );

  assign span32 = range_high - range_low;
  assign span16 = range_high[HALF_W-1:0] - range_low[HALF_W-1:0];

  always_comb begin
    entry     = '0;
    entry.raw = raw;
    entry.low = range_low;
    entry.err = gen_err;
    unique case (operation)
      OP_DRAW16: begin
        entry.kind    = KIND_DRAW16;
        entry.divisor = {{HALF_W{1'b0}}, span16} + WORD_W'(1);
      end
      OP_DRAW32: begin
        entry.kind    = KIND_DRAW32;
        entry.divisor = span32 + WORD_W'(1);
      end
      default: begin
        entry.kind = KIND_NONE;
      end
    endcase
  end

  assign lanes[0]  = entry;
  assign valids[0] = accept;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    xrr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (valids[i]),
      .lane_in   (lanes[i]),
      .valid_out (valids[i+1]),
      .lane_out  (lanes[i+1])
    );
  end

  assign last  = lanes[CELLS];
  assign sum16 = last.low[HALF_W-1:0] + last.rem[HALF_W-1:0];

  always_comb begin
    case (last.kind)
      KIND_DRAW16: value_nxt = {{HALF_W{1'b0}}, sum16};
      KIND_DRAW32: value_nxt = last.low + last.rem;
      default:     value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valids[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r      <= value_nxt;
      seed_error_r <= last.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, seed_error_r, value_r};

endmodule
